FILE: rtl/srtf_pkg.sv
// Package with the payload types, queue entry type and constants of the routed SPI framer.
package srtf_pkg;

    // Configuration port geometry: one route id register per chip select.
    localparam int CFG_NUM_REGS = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int ROUTE_W      = 8;

    // Header constants.
    localparam logic [7:0] LONG_MARK    = 8'h80;
    localparam logic [7:0] ZERO_BYTE    = 8'h00;
    localparam logic [2:0] SHORT_EXTRA  = 3'd3;
    localparam logic [2:0] LONG_EXTRA   = 3'd5;
    localparam logic [2:0] DIRECT_EXTRA = 3'd0;

    // One accepted input item.
    typedef struct packed {
        logic [7:0]  data_byte;
        logic [15:0] transfer_length;
        logic [1:0]  cs_sel;
        logic        final_transfer;
        logic        last_byte;
    } t_in_item;

    // One delivered result word.
    typedef struct packed {
        logic [15:0] word;
        logic [16:0] byte_count;
        logic        last_word;
    } t_out_item;

    // Words produced by one input item: one or two words sharing a byte count.
    // The fin flag marks the final word of the entry as the end of the transfer.
    typedef struct packed {
        logic [15:0] w0;
        logic [15:0] w1;
        logic [16:0] byte_count;
        logic        two;
        logic        fin;
    } t_entry;

endpackage

FILE: rtl/srtf_frame.sv
// Framing logic: header, payload pairing, trailer and padding for one byte per cycle while bytes are accepted.
module srtf_frame
    import srtf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  t_in_item             i_item,
    input  logic [ROUTE_W-1:0]   i_route,
    output logic                 o_push,
    output t_entry               o_entry
);

    logic [7:0] r_held_byte;
    logic       r_held_valid;
    logic       r_in_xfer;
    logic [7:0] n_held_byte;
    logic       n_held_valid;
    logic       n_in_xfer;

    logic        routed;
    logic        short_len;
    logic        first;
    logic        held_ok;
    logic        eff_last;
    logic [7:0]  hdr0;
    logic [2:0]  extra;
    logic [16:0] count;

    // Decode the item against the selected route.
    always_comb begin
        routed    = (i_route != '0);
        short_len = (i_item.transfer_length[15:7] == '0);
        first     = !r_in_xfer;
        held_ok   = r_held_valid && !first;
        // A long header forces the transfer to continue past the first byte.
        eff_last  = i_item.last_byte && !(first && routed && !short_len);
        hdr0      = {!i_item.final_transfer, i_route[6:0]};
        if (!routed) begin
            extra = DIRECT_EXTRA;
        end else if (short_len) begin
            extra = SHORT_EXTRA;
        end else begin
            extra = LONG_EXTRA;
        end
        count = {1'b0, i_item.transfer_length} + {14'd0, extra};
    end

    // Build the words of this item and the next framing state.
    always_comb begin
        o_push               = 1'b0;
        o_entry.w0           = '0;
        o_entry.w1           = '0;
        o_entry.byte_count   = count;
        o_entry.two          = 1'b0;
        o_entry.fin          = 1'b0;
        n_held_byte          = r_held_byte;
        n_held_valid         = r_held_valid;
        n_in_xfer            = r_in_xfer;

        if (first && routed) begin
            o_push = 1'b1;
            if (!short_len) begin
                // Long header: header byte (not-final flag, route bits 6:0), mark, then the 16-bit length.
                o_entry.w0   = {hdr0, LONG_MARK};
                o_entry.w1   = i_item.transfer_length;
                o_entry.two  = 1'b1;
                n_held_byte  = i_item.data_byte;
                n_held_valid = 1'b1;
            end else if (eff_last) begin
                // Single-byte transfer: header word, then the byte with a zero trailer.
                o_entry.w0   = {hdr0, i_item.transfer_length[7:0]};
                o_entry.w1   = {i_item.data_byte, ZERO_BYTE};
                o_entry.two  = 1'b1;
                o_entry.fin  = 1'b1;
                n_held_valid = 1'b0;
            end else begin
                o_entry.w0   = {hdr0, i_item.transfer_length[7:0]};
                n_held_byte  = i_item.data_byte;
                n_held_valid = 1'b1;
            end
        end else if (!eff_last) begin
            // Payload bytes pair up into words.
            if (held_ok) begin
                o_push       = 1'b1;
                o_entry.w0   = {r_held_byte, i_item.data_byte};
                n_held_valid = 1'b0;
            end else begin
                n_held_byte  = i_item.data_byte;
                n_held_valid = 1'b1;
            end
        end else begin
            // Final payload byte: close with trailer and padding as needed.
            o_push       = 1'b1;
            o_entry.fin  = 1'b1;
            n_held_valid = 1'b0;
            if (held_ok) begin
                o_entry.w0  = {r_held_byte, i_item.data_byte};
                o_entry.two = routed;
            end else begin
                o_entry.w0  = {i_item.data_byte, ZERO_BYTE};
            end
        end
        n_in_xfer = !eff_last;
    end

    // Held byte is payload and needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_held_byte <= n_held_byte;
        end
    end

    // Framing control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
            r_in_xfer    <= 1'b0;
        end else if (i_accept) begin
            r_held_valid <= n_held_valid;
            r_in_xfer    <= n_in_xfer;
        end
    end

endmodule

FILE: rtl/spi_routed_transfer_framer_unit.sv
// Top level of the routed SPI transfer framer: route registers, framing logic and output queue.
// An item's words are registered in the output queue. Throughput: one item per cycle unless
// the input stalls; an item yields zero, one or two words, one word per cycle leaves the block
// unless i_out_stall holds it, and a two-entry output queue absorbs the two-word items.
// The input stalls only while both queue entries are held and none retires this cycle.
// Reset (synchronous, active low) clears the route ids to zero, the framing state and the queue.
module spi_routed_transfer_framer_unit
    import srtf_pkg::*;
#(
    parameter int NUM_CHIP_SELECTS = 4
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ROUTE_W-1:0]   i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data
);

    localparam int NUM_REGS = (NUM_CHIP_SELECTS < CFG_NUM_REGS) ? NUM_CHIP_SELECTS
                                                                 : CFG_NUM_REGS;

    logic [ROUTE_W-1:0] route_tab [CFG_NUM_REGS];
    logic [ROUTE_W-1:0] route;
    logic               in_accept;
    logic               push;
    t_entry             entry;

    t_entry     r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;
    logic       r_half;
    logic [1:0] n_cnt;
    logic       n_half;
    t_entry     head;
    logic       out_xfer;
    logic       pop;

    // Route id registers exist only for chip selects that are present; others read zero.
    for (genvar i = 0; i < CFG_NUM_REGS; i++) begin : g_route
        if (i < NUM_REGS) begin : g_reg
            logic [ROUTE_W-1:0] r_route;
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_route <= '0;
                end else if (i_cfg_we && (i_cfg_index == CFG_IDX_W'(i))) begin
                    r_route <= i_cfg_data;
                end
            end
            assign route_tab[i] = r_route;
        end else begin : g_none
            assign route_tab[i] = '0;
        end
    end

    assign route = route_tab[i_in_data.cs_sel];

    // Queue head and handshake.
    assign head        = r_q[r_rd_ptr];
    assign o_out_valid = (r_cnt != 2'd0);
    assign out_xfer    = o_out_valid && !i_out_stall;
    assign pop         = out_xfer && (r_half == head.two);
    assign o_in_stall  = (r_cnt == 2'd2) && !pop;
    assign in_accept   = i_in_valid && !o_in_stall;

    // Output word selection.
    always_comb begin
        o_out_data.word       = r_half ? head.w1 : head.w0;
        o_out_data.byte_count = head.byte_count;
        o_out_data.last_word  = head.fin && (r_half == head.two);
    end

    srtf_frame u_frame (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_item   (i_in_data),
        .i_route  (route),
        .o_push   (push),
        .o_entry  (entry)
    );

    // Queue occupancy and word position within the head entry.
    always_comb begin
        n_cnt  = r_cnt + {1'b0, in_accept && push} - {1'b0, pop};
        n_half = r_half;
        if (pop) begin
            n_half = 1'b0;
        end else if (out_xfer) begin
            n_half = 1'b1;
        end
    end

    // Queue storage is payload and needs no reset.
    always_ff @(posedge i_clk) begin
        if (in_accept && push) begin
            r_q[r_wr_ptr] <= entry;
        end
    end

    // Queue control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
            r_half   <= 1'b0;
        end else begin
            if (in_accept && push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_cnt  <= n_cnt;
            r_half <= n_half;
        end
    end

    // A write into a full queue must coincide with the head entry retiring.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && push && (r_cnt == 2'd2)) |-> pop)
        else $error("output queue overflow");

    // The second word position is only used on a held two-word entry.
    a_half_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_half |-> (o_out_valid && head.two))
        else $error("second word selected without a two-word entry");

    // A second word that waits under stall keeps its entry at the head.
    a_half_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_half && i_out_stall) |=> (r_half && $stable(r_rd_ptr)))
        else $error("second word lost while stalled");

    // Reset leaves the queue empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> ((r_cnt == 2'd0) && !r_half))
        else $error("queue not empty after reset");

endmodule

FILE: dv/srtf_checker.sv
// Checker for the routed SPI framer: predicts the framed words and compares them at the output.
`timescale 1ns / 1ps

module srtf_checker
    import srtf_pkg::*;
#(
    parameter int NUM_CS = 4
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ROUTE_W-1:0]   i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  t_in_item             i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  t_out_item            i_out_data,
    output int                   o_words_owed,
    output int                   o_error_count
);

    // Shadow copy of the route registers and of the framing state.
    logic [ROUTE_W-1:0] route_ids [CFG_NUM_REGS];
    logic [7:0]         held_byte;
    logic               held_valid;
    logic               in_frame;
    t_out_item          framed_words_due[$];
    int                 errors;

    task automatic queue_word(input logic [15:0] w, input logic [16:0] cnt, input logic fin);
        t_out_item e;
        e.word       = w;
        e.byte_count = cnt;
        e.last_word  = fin;
        framed_words_due.push_back(e);
    endtask

    // Works out the words that one accepted payload byte releases.
    task automatic frame_item(input t_in_item it);
        logic [7:0]  route;
        logic [16:0] count;
        logic [7:0]  hdr;
        logic        ends;
        route = (it.cs_sel < NUM_CS) ? route_ids[it.cs_sel] : 8'h00;
        ends  = it.last_byte;

        // The byte count follows this item's route and length.
        if (route == 8'h00) begin
            count = {1'b0, it.transfer_length} + DIRECT_EXTRA;
        end else if (it.transfer_length < 16'd128) begin
            count = {1'b0, it.transfer_length} + SHORT_EXTRA;
        end else begin
            count = {1'b0, it.transfer_length} + LONG_EXTRA;
        end

        // The first byte of an SPI transfer fixes the header.
        if (!in_frame) begin
            in_frame   = 1'b1;
            held_valid = 1'b0;
            if (route != 8'h00) begin
                hdr = it.final_transfer ? {1'b0, route[6:0]} : {1'b1, route[6:0]};
                if (it.transfer_length < 16'd128) begin
                    queue_word({hdr, it.transfer_length[7:0]}, count, 1'b0);
                end else begin
                    // A long header swallows a last-byte flag on the first byte.
                    queue_word({hdr, LONG_MARK}, count, 1'b0);
                    queue_word(it.transfer_length, count, 1'b0);
                    ends = 1'b0;
                end
            end
        end

        if (!ends) begin
            if (held_valid) begin
                queue_word({held_byte, it.data_byte}, count, 1'b0);
                held_valid = 1'b0;
            end else begin
                held_byte  = it.data_byte;
                held_valid = 1'b1;
            end
        end else begin
            // Final byte: pair it, add the trailer on routed transfers, or pad.
            if (held_valid) begin
                if (route != 8'h00) begin
                    queue_word({held_byte, it.data_byte}, count, 1'b0);
                    queue_word({ZERO_BYTE, ZERO_BYTE}, count, 1'b1);
                end else begin
                    queue_word({held_byte, it.data_byte}, count, 1'b1);
                end
            end else begin
                queue_word({it.data_byte, ZERO_BYTE}, count, 1'b1);
            end
            held_byte  = 8'h00;
            held_valid = 1'b0;
            in_frame   = 1'b0;
        end
    endtask

    // Watch both channels and the register port on every rising edge.
    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            for (int i = 0; i < CFG_NUM_REGS; i++) begin
                route_ids[i] = '0;
            end
            held_byte  = 8'h00;
            held_valid = 1'b0;
            in_frame   = 1'b0;
            framed_words_due.delete();
        end else begin
            if (i_cfg_we) begin
                route_ids[i_cfg_index] = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                frame_item(i_in_data);
            end
            if (i_out_valid && !i_out_stall) begin
                if (framed_words_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected word %h count %0d last %0b", $time,
                             i_out_data.word, i_out_data.byte_count, i_out_data.last_word);
                end else begin
                    want = framed_words_due.pop_front();
                    if (i_out_data.word !== want.word ||
                        i_out_data.byte_count !== want.byte_count ||
                        i_out_data.last_word !== want.last_word) begin
                        errors++;
                        $display("%0t: expected word %h count %0d last %0b, got %h %0d %0b",
                                 $time, want.word, want.byte_count, want.last_word,
                                 i_out_data.word, i_out_data.byte_count,
                                 i_out_data.last_word);
                    end
                end
            end
        end
        o_words_owed  <= framed_words_due.size();
        o_error_count <= errors;
    end

endmodule

FILE: dv/tb_top.sv
// Testbench top for the routed SPI framer: clock, reset, stimulus and the final verdict.
`timescale 1ns / 1ps

module tb_top
    import srtf_pkg::*;
();

    // Register indexes of the route id registers.
    localparam logic [CFG_IDX_W-1:0] REG_ROUTE_CS0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROUTE_CS1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROUTE_CS2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROUTE_CS3 = 2'd3;

    localparam int TARGET_ITEMS = 1950;
    localparam int IDLE_PCT     = 36;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [ROUTE_W-1:0]   i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_in_item             i_in_data;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_out_item            o_out_data;
    int                   words_owed;
    int                   error_count;

    int items_sent;
    bit calm;
    int hold_requests;
    int holds_served;
    int hold_left;

    spi_routed_transfer_framer_unit #(.NUM_CHIP_SELECTS(4)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    srtf_checker #(.NUM_CS(4)) checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_in_data     (i_in_data),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_out_data    (o_out_data),
        .o_words_owed  (words_owed),
        .o_error_count (error_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard limit on the run time.
    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Receiver: random stalls, calm stretches and long hold-offs on request.
    initial begin
        i_out_stall  <= 1'b0;
        holds_served = 0;
        hold_left    = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else if (hold_requests != holds_served) begin
                holds_served = hold_requests;
                hold_left    = HOLD_CYCLES - 1;
                i_out_stall  <= 1'b1;
            end else if (calm) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // Offer one payload byte and wait for its transfer.
    task automatic push_item(input t_in_item it);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] data, input logic [15:0] len,
                             input logic [1:0] cs, input logic fin, input logic last);
        t_in_item it;
        it.data_byte       = data;
        it.transfer_length = len;
        it.cs_sel          = cs;
        it.final_transfer  = fin;
        it.last_byte       = last;
        push_item(it);
    endtask

    // Stop sending and wait until every expected word has left the block.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        wait (words_owed == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_routes(input logic [7:0] r0, input logic [7:0] r1,
                              input logic [7:0] r2, input logic [7:0] r3);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_ROUTE_CS0;
        i_cfg_data  <= r0;
        @(posedge i_clk);
        i_cfg_index <= REG_ROUTE_CS1;
        i_cfg_data  <= r1;
        @(posedge i_clk);
        i_cfg_index <= REG_ROUTE_CS2;
        i_cfg_data  <= r2;
        @(posedge i_clk);
        i_cfg_index <= REG_ROUTE_CS3;
        i_cfg_data  <= r3;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] pick_route();
        case ($urandom_range(5))
            0: pick_route = 8'h00;
            1: pick_route = 8'hFF;
            2: pick_route = 8'h80;
            3: pick_route = 8'h7F;
            default: pick_route = 8'($urandom);
        endcase
    endfunction

    // One SPI transfer; noisy ones get some bytes with all fields scrambled.
    task automatic send_transfer(input logic [1:0] cs, input logic [15:0] len,
                                 input int nbytes, input logic fin, input bit noisy);
        t_in_item it;
        for (int k = 0; k < nbytes; k++) begin
            if (noisy && $urandom_range(7) == 0) begin
                it = t_in_item'($urandom);
            end else begin
                it.data_byte       = 8'($urandom);
                it.transfer_length = len;
                it.cs_sel          = cs;
                it.final_transfer  = fin;
                it.last_byte       = (k == nbytes - 1);
            end
            push_item(it);
        end
    endtask

    // Stimulus: reset, directed cases, then random SPI transfers.
    initial begin : stimulus
        int          xfer;
        int          pick;
        int          nbytes;
        logic [15:0] len;
        bit          noisy;

        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        i_in_valid    <= 1'b0;
        i_in_data     <= '0;
        items_sent    = 0;
        calm          = 1'b0;
        hold_requests = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Direct transfers with the route ids at their reset value.
        send_byte(8'h00, 16'd1, 2'd0, 1'b1, 1'b1);
        send_byte(8'hFF, 16'd3, 2'd1, 1'b0, 1'b0);
        send_byte(8'hA5, 16'd3, 2'd1, 1'b0, 1'b0);
        send_byte(8'h5A, 16'd3, 2'd1, 1'b0, 1'b1);
        settle();
        set_routes(8'h7F, 8'hFF, 8'h01, 8'h00);

        // Short header on the final transfer of a message, single byte.
        send_byte(8'hFF, 16'd1, 2'd0, 1'b1, 1'b1);
        // Longest short length, not final.
        send_byte(8'h12, 16'd127, 2'd1, 1'b0, 1'b0);
        send_byte(8'h34, 16'd127, 2'd1, 1'b0, 1'b1);
        // Long header where the first byte also carries the last-byte flag.
        send_byte(8'h56, 16'd128, 2'd2, 1'b1, 1'b1);
        send_byte(8'h78, 16'd128, 2'd2, 1'b1, 1'b1);
        // Largest length with a long header.
        send_byte(8'h10, 16'hFFFF, 2'd1, 1'b0, 1'b0);
        send_byte(8'h11, 16'hFFFF, 2'd1, 1'b0, 1'b0);
        send_byte(8'h12, 16'hFFFF, 2'd1, 1'b0, 1'b1);
        // Zero length on a routed chip select.
        send_byte(8'h9C, 16'd0, 2'd0, 1'b0, 1'b1);
        // Direct chip select with an even payload.
        send_byte(8'hC3, 16'd2, 2'd3, 1'b0, 1'b0);
        send_byte(8'h3C, 16'd2, 2'd3, 1'b1, 1'b1);
        // Route and length change while a transfer is under way.
        send_byte(8'h01, 16'd5, 2'd0, 1'b0, 1'b0);
        send_byte(8'h02, 16'd200, 2'd3, 1'b1, 1'b0);
        send_byte(8'h03, 16'd1, 2'd1, 1'b0, 1'b1);
        // Zero length on a direct chip select.
        send_byte(8'h44, 16'd0, 2'd3, 1'b0, 1'b1);

        // Random SPI transfers, mostly well formed.
        xfer = 0;
        while (items_sent < TARGET_ITEMS) begin
            if (xfer % 8 == 0) begin
                settle();
                set_routes(pick_route(), pick_route(), pick_route(), pick_route());
            end
            calm  = (xfer >= 24 && xfer < 32);
            noisy = ($urandom_range(9) == 0);
            pick  = $urandom_range(99);
            if (pick < 65) begin
                len    = 16'($urandom_range(12, 1));
                nbytes = len;
            end else if (pick < 85) begin
                len    = 16'($urandom_range(127, 13));
                nbytes = len;
            end else if (pick < 93) begin
                len    = 16'($urandom_range(200, 128));
                nbytes = len;
            end else if (pick < 97) begin
                len    = 16'($urandom_range(65535, 201));
                nbytes = $urandom_range(40, 1);
            end else begin
                len    = 16'd0;
                nbytes = $urandom_range(4, 1);
            end
            if (xfer == 5) begin
                // Long receiver hold-off while the sender keeps offering bytes.
                hold_requests++;
                calm   = 1'b1;
                noisy  = 1'b0;
                len    = 16'd48;
                nbytes = 48;
            end
            send_transfer(2'($urandom), len, nbytes, 1'($urandom), noisy);
            calm = 1'b0;
            xfer++;
        end

        settle();
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/srtf_pkg.sv
rtl/srtf_frame.sv
rtl/spi_routed_transfer_framer_unit.sv
dv/srtf_checker.sv
dv/tb_top.sv
